// File: hdl/fcsl_pkg.sv
package fcsl_pkg;

  localparam int MaxPoints = 8;
  localparam int IdxW = 3;
  localparam int CntW = 4;

  localparam logic [1:0] StLookup = 2'd0;
  localparam logic [1:0] StStaged = 2'd1;
  localparam logic [1:0] StAccept = 2'd2;
  localparam logic [1:0] StReject = 2'd3;

  localparam logic OpLoad = 1'b0;
  localparam logic OpLookup = 1'b1;

  typedef struct packed {
    logic               operation;
    logic [IdxW-1:0]    point_index;
    logic signed [15:0] temperature;
    logic [7:0]         point_duty;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] duty;
  } out_item_t;

  // controller -> datapath commands
  typedef struct packed {
    logic            capture;
    logic            stage_wr;
    logic            chk_clear;
    logic            chk_step;
    logic [IdxW-1:0] chk_idx;
    logic            commit_step;
    logic            commit_done;
    logic            seg_step;
    logic [IdxW-1:0] seg_idx;
    logic            seg_load;
    logic            div_start;
    logic            div_step;
    logic [2:0]      mac_step;
    logic            finish;
  } fcsl_cmd_t;

  typedef struct packed {
    logic            lookup;
    logic            last;
    logic [CntW-1:0] count;
    logic [CntW-1:0] req_count;
    logic            chk_ok;
    logic            clamp_hit;
    logic            seg_found;
  } fcsl_stat_t;

endpackage

// File: hdl/fan_curve_spline_lookup_unit.sv
// throughput: one item in flight; next accepted after the result beat is taken
// cycle count set by the 8-slot check, segment walk, 16-step divider for t, weight mac steps
// reset: rst synchronous, clears controller, no active curve, min_safe_duty 20
module fan_curve_spline_lookup_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  fcsl_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fcsl_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);
  import fcsl_pkg::*;

  fcsl_cmd_t  cmd;
  fcsl_stat_t stat;
  logic [6:0] min_safe_duty;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) min_safe_duty <= 7'd20;
    else if (cfg_valid) min_safe_duty <= cfg_data;
  end

  fcsl_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  fcsl_dp u_dp (
    .clk, .rst, .in_item(in_data), .min_safe_duty, .cmd, .stat, .out_item(out_data)
  );
endmodule

// File: hdl/fcsl_ctrl.sv
module fcsl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  fcsl_pkg::fcsl_stat_t stat,
  output fcsl_pkg::fcsl_cmd_t  cmd
);
  import fcsl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_CHECK, S_COMMIT, S_CLAMP, S_SEARCH, S_SEGLD,
    S_DIV, S_MAC, S_FIN, S_OUT
  } state_t;

  state_t          state;
  logic [4:0]      cnt;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.chk_idx = cnt[IdxW-1:0];
    cmd.seg_idx = cnt[IdxW-1:0];
    unique case (state)
      S_DISPATCH: begin
        cmd.stage_wr = !stat.lookup;
        cmd.chk_clear = 1'b1;
      end
      S_CHECK: cmd.chk_step = 1'b1;
      S_COMMIT: begin
        cmd.commit_step = 1'b1;
        cmd.commit_done = (cnt == 5'(stat.req_count) - 5'd1);
      end
      S_SEARCH: cmd.seg_step = 1'b1;
      S_SEGLD: begin
        cmd.seg_load = 1'b1;
        cmd.div_start = 1'b1;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_MAC: cmd.mac_step = cnt[2:0];
      S_FIN: cmd.finish = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_DISPATCH;
        S_DISPATCH: begin
          cnt <= '0;
          if (stat.lookup) state <= S_CLAMP;
          else if (stat.last) state <= S_CHECK;
          else state <= S_FIN;
        end
        S_CHECK: begin
          // walk all slots; checker masks those beyond the requested point count
          if (cnt == 5'(MaxPoints - 1)) begin
            cnt <= '0;
            state <= S_COMMIT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_COMMIT: begin
          if (!stat.chk_ok || cmd.commit_done) state <= S_FIN;
          else cnt <= cnt + 5'd1;
        end
        S_CLAMP: state <= stat.clamp_hit ? S_FIN : S_SEARCH;
        S_SEARCH: begin
          if (stat.seg_found || cnt == 5'(MaxPoints - 2)) state <= S_SEGLD;
          else cnt <= cnt + 5'd1;
        end
        S_SEGLD: begin
          cnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          if (cnt == 5'd15) begin
            cnt <= '0;
            state <= S_MAC;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_MAC: begin
          if (cnt == 5'd6) state <= S_FIN;
          else cnt <= cnt + 5'd1;
        end
        S_FIN: state <= S_OUT;
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall)) else $error("accept while holding result");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_cap_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_DISPATCH) else $error("capture lost");
endmodule

// File: hdl/fcsl_dp.sv
module fcsl_dp (
  input  logic                clk,
  input  logic                rst,
  input  fcsl_pkg::in_item_t  in_item,
  input  logic [6:0]          min_safe_duty,
  input  fcsl_pkg::fcsl_cmd_t cmd,
  output fcsl_pkg::fcsl_stat_t stat,
  output fcsl_pkg::out_item_t out_item
);
  import fcsl_pkg::*;

  in_item_t           item;
  logic signed [15:0] st_t [MaxPoints];
  logic [7:0]         st_d [MaxPoints];
  logic signed [15:0] ac_t [MaxPoints];
  logic [6:0]         ac_d [MaxPoints];
  logic [CntW-1:0]    ac_cnt;
  logic               ok;
  logic [1:0]         res_status;
  logic [6:0]         res_duty;

  // lookup working regs
  logic [IdxW-1:0]    seg;
  logic               found;
  logic [16:0]        den_r;
  logic [16:0]        rem;
  logic [16:0]        quo;
  logic signed [7:0]  d0, d1, d2, d3;
  logic signed [35:0] u2;
  logic signed [52:0] u3;
  logic signed [63:0] acc;
  logic signed [52:0] wt;
  logic               direct;

  logic [CntW-1:0] req;
  assign req = CntW'(item.point_index) + CntW'(1);

  assign stat.lookup = item.operation == OpLookup;
  assign stat.last = item.last_point;
  assign stat.count = ac_cnt;
  assign stat.req_count = req;
  assign stat.chk_ok = ok;
  assign stat.seg_found = found;

  logic [IdxW-1:0] last_i;
  assign last_i = IdxW'(ac_cnt - CntW'(1));
  assign stat.clamp_hit = (ac_cnt == '0) || (item.temperature <= ac_t[0])
                          || (item.temperature >= ac_t[last_i]);

  // check one slot
  logic [IdxW-1:0] k;
  logic [IdxW-1:0] kp;
  logic            bad;
  assign k = cmd.chk_idx;
  assign kp = k - IdxW'(1);
  always_comb begin
    bad = 1'b0;
    if (CntW'(k) < req) begin
      if ({1'b0, st_d[k]} < {2'b0, min_safe_duty} || st_d[k] > 8'd100) bad = 1'b1;
      if (k != '0 && (st_t[k] <= st_t[kp] || st_d[k] < st_d[kp])) bad = 1'b1;
      if (k == '0 && (st_t[0] > 16'sd2 || st_t[0] < -16'sd2)) bad = 1'b1;
    end
  end

  // weight step terms, scaled by 2^48 (u as Q16)
  logic signed [52:0] us2, s3, u2s, u3e;
  assign us2 = 53'(signed'({1'b0, quo[15:0]})) <<< 32;
  assign s3  = 53'sd1 <<< 48;
  assign u2s = 53'(u2) <<< 16;
  assign u3e = u3;
  logic signed [7:0] dsel;
  always_comb begin
    wt = '0;
    dsel = '0;
    case (cmd.mac_step)
      3'd3: begin wt = -u3e + (u2s <<< 1) - us2; dsel = d0; end
      3'd4: begin wt = 3 * u3e - 5 * u2s + (s3 <<< 1); dsel = d1; end
      3'd5: begin wt = -3 * u3e + (u2s <<< 2) + us2; dsel = d2; end
      3'd6: begin wt = u3e - u2s; dsel = d3; end
      default: ;
    endcase
  end

  logic [IdxW-1:0] i0, i3, ip1;
  assign ip1 = seg + IdxW'(1);
  assign i0 = (seg != '0) ? seg - IdxW'(1) : seg;
  assign i3 = (CntW'(seg) + CntW'(2) < ac_cnt) ? seg + IdxW'(2) : ip1;

  logic [17:0] rem_sh;
  assign rem_sh = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      ac_cnt <= '0;
    end else begin
      if (cmd.capture) item <= in_item;
      if (cmd.stage_wr && CntW'(item.point_index) < CntW'(MaxPoints)) begin
        st_t[item.point_index] <= item.temperature;
        st_d[item.point_index] <= item.point_duty;
      end
      if (cmd.chk_clear) begin
        ok <= (req >= CntW'(2));
        found <= 1'b0;
        seg <= '0;
        direct <= 1'b0;
      end
      if (cmd.chk_step && bad) ok <= 1'b0;
      if (cmd.commit_step && ok) begin
        ac_t[k] <= st_t[k];
        ac_d[k] <= st_d[k][6:0];
        if (cmd.commit_done) ac_cnt <= req;
      end
      if (cmd.seg_step && !found) begin
        seg <= cmd.seg_idx;
        if (item.temperature >= ac_t[cmd.seg_idx]
            && item.temperature < ac_t[cmd.seg_idx + IdxW'(1)]) found <= 1'b1;
      end
      if (cmd.seg_load) begin
        d0 <= 8'(ac_d[i0]);
        d1 <= 8'(ac_d[seg]);
        d2 <= 8'(ac_d[ip1]);
        d3 <= 8'(ac_d[i3]);
        // num < den, so the remainder starts as num
        rem <= 17'(item.temperature - ac_t[seg]);
        den_r <= 17'(ac_t[ip1] - ac_t[seg]);
        quo <= '0;
        acc <= '0;
      end
      // restoring divide of num*2^16 by den, one quotient bit per step
      if (cmd.div_step) begin
        if (rem_sh[16:0] >= den_r || rem_sh[17]) begin
          rem <= 17'(rem_sh - {1'b0, den_r});
          quo <= {quo[15:0], 1'b1};
        end else begin
          rem <= rem_sh[16:0];
          quo <= {quo[15:0], 1'b0};
        end
      end
      case (cmd.mac_step)
        3'd1: u2 <= 36'(signed'({1'b0, quo[15:0]}) * signed'({1'b0, quo[15:0]}));
        3'd2: u3 <= 53'(u2 * signed'({1'b0, quo[15:0]}));
        default: ;
      endcase
      if (cmd.mac_step >= 3'd3) acc <= acc + 64'(wt * dsel);
      if (cmd.finish) begin
        if (item.operation == OpLookup) begin
          res_status <= StLookup;
          if (ac_cnt == '0) res_duty <= 7'd100;
          else if (item.temperature <= ac_t[0]) res_duty <= ac_d[0];
          else if (item.temperature >= ac_t[last_i]) res_duty <= ac_d[last_i];
          else if (acc < 0) res_duty <= '0;
          else if ((acc >>> 49) > 64'sd100) res_duty <= 7'd100;
          else res_duty <= 7'(acc >>> 49);
        end else begin
          res_duty <= '0;
          if (!item.last_point) res_status <= StStaged;
          else res_status <= ok ? StAccept : StReject;
        end
      end
    end
  end

  assign out_item.status = res_status;
  assign out_item.duty = res_duty;

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    ac_cnt == '0 || (ac_cnt >= CntW'(2) && ac_cnt <= CntW'(MaxPoints)))
    else $error("bad active count");
  a_cnt_commit: assert property (@(posedge clk) disable iff (rst)
    ac_cnt != $past(ac_cnt) |-> $past(cmd.commit_done))
    else $error("count changed outside commit");
  a_dir: assert property (@(posedge clk) disable iff (rst)
    cmd.seg_load |-> !direct) else $error("seg load on direct");
endmodule

// File: sim/tb_fan_curve_spline_lookup_unit.sv
module tb_fan_curve_spline_lookup_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import fcsl_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [6:0] cfg_data;

  fan_curve_spline_lookup_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // curve model state
  logic signed [15:0] act_temp [MaxPoints];
  logic [6:0]         act_duty [MaxPoints];
  int                 act_count;
  logic signed [15:0] stg_temp [MaxPoints];
  logic [7:0]         stg_duty [MaxPoints];
  logic [6:0]         min_duty;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        idle_pct;
  int        stall_pct;
  int        hold_left;
  int        results_seen;
  int        fail_cnt;

  // generator view of the last curve it built
  int gen_lo;
  int gen_hi;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

  function automatic logic [6:0] spline_duty(int i, int temp);
    int      i0, i3;
    longint  d0, d1, d2, d3, num, den, u, u3, u2s, us2, s3, w0, w1, w2, w3, sum, r;
    i0 = (i > 0) ? i - 1 : i;
    i3 = (i + 2 < act_count) ? i + 2 : i + 1;
    d0 = act_duty[i0];
    d1 = act_duty[i];
    d2 = act_duty[i + 1];
    d3 = act_duty[i3];
    num = longint'(temp - int'(act_temp[i])) <<< 16;
    den = longint'(int'(act_temp[i + 1]) - int'(act_temp[i]));
    if (den <= 0) return act_duty[i];
    u = num / den;
    if (u > 65535) u = 65535;
    u3  = u * u * u;
    u2s = u * u * 65536;
    us2 = u <<< 32;
    s3  = longint'(1) <<< 48;
    w0 = -u3 + 2 * u2s - us2;
    w1 = 3 * u3 - 5 * u2s + 2 * s3;
    w2 = -3 * u3 + 4 * u2s + us2;
    w3 = u3 - u2s;
    sum = w0 * d0 + w1 * d1 + w2 * d2 + w3 * d3;
    if (sum < 0) return 7'd0;
    r = sum / (longint'(1) <<< 49);
    if (r > 100) r = 100;
    return r[6:0];
  endfunction

  function automatic logic [6:0] lookup_duty(int temp);
    if (act_count == 0) return 7'd100;
    if (temp <= int'(act_temp[0])) return act_duty[0];
    if (temp >= int'(act_temp[act_count - 1])) return act_duty[act_count - 1];
    for (int i = 0; i + 1 < act_count; i++)
      if (temp >= int'(act_temp[i]) && temp < int'(act_temp[i + 1]))
        return spline_duty(i, temp);
    return act_duty[act_count - 1];
  endfunction

  function automatic bit staged_curve_ok(int n);
    if (n < 2 || n > MaxPoints) return 1'b0;
    for (int k = 0; k < n; k++) begin
      if (stg_duty[k] < {1'b0, min_duty} || stg_duty[k] > 8'd100) return 1'b0;
      if (k > 0 && stg_temp[k] <= stg_temp[k - 1]) return 1'b0;
      if (k > 0 && stg_duty[k] < stg_duty[k - 1]) return 1'b0;
    end
    if (stg_temp[0] > 2 || stg_temp[0] < -2) return 1'b0;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_curve_result(in_item_t it);
    out_item_t res;
    int        n;
    res.duty = '0;
    if (it.operation == OpLookup) begin
      res.status = StLookup;
      res.duty   = lookup_duty(int'(it.temperature));
      return res;
    end
    stg_temp[it.point_index] = it.temperature;
    stg_duty[it.point_index] = it.point_duty;
    if (!it.last_point) begin
      res.status = StStaged;
      return res;
    end
    n = int'(it.point_index) + 1;
    if (staged_curve_ok(n)) begin
      for (int k = 0; k < n; k++) begin
        act_temp[k] = stg_temp[k];
        act_duty[k] = stg_duty[k][6:0];
      end
      act_count  = n;
      res.status = StAccept;
    end else begin
      res.status = StReject;
    end
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(predict_curve_result(in_data));
      if (!in_valid || !in_stall) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
          in_data  <= pending_items.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (results_seen == 150) hold_left = 300;
        if (expected_results.size() == 0) begin
          $error("unexpected result beat status=%0d duty=%0d", out_data.status, out_data.duty);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, out_data.status);
            fail_cnt++;
          end
          if (out_data.duty !== want.duty) begin
            $error("duty: expected %0d actual %0d", want.duty, out_data.duty);
            fail_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic push_load(int idx, int temp, int duty, bit last);
    in_item_t it;
    it.operation   = OpLoad;
    it.point_index = idx[IdxW-1:0];
    it.temperature = temp[15:0];
    it.point_duty  = duty[7:0];
    it.last_point  = last;
    pending_items.push_back(it);
  endtask

  task automatic push_lookup(int temp);
    in_item_t it;
    it.operation   = OpLookup;
    it.point_index = $urandom_range(7);
    it.temperature = temp[15:0];
    it.point_duty  = $urandom_range(255);
    it.last_point  = $urandom_range(1);
    pending_items.push_back(it);
  endtask

  // well-formed curve with random content, now and then broken on purpose
  task automatic push_curve(int mind);
    int n, temp, duty, flaw, bad_k, step_max;
    n        = $urandom_range(2, MaxPoints);
    flaw     = ($urandom_range(99) < 20) ? $urandom_range(1, 5) : 0;
    bad_k    = $urandom_range(n - 1);
    step_max = ($urandom_range(9) == 0) ? 9000 : 3000;
    temp     = $urandom_range(4) - 2;
    duty     = (mind > 100) ? 100 : $urandom_range(mind, (mind + 100) / 2);
    gen_lo   = temp;
    for (int k = 0; k < n; k++) begin
      int pt, pd;
      if (k > 0) begin
        temp += $urandom_range(1, step_max);
        if (temp > 32767) temp = 32767;
        duty += $urandom_range(0, (100 - duty) / 2 + 1);
        if (duty > 100) duty = 100;
      end
      pt = temp;
      pd = duty;
      if (k == bad_k) begin
        case (flaw)
          1: pd = $urandom_range(101, 255);
          2: pd = (mind > 0) ? $urandom_range(0, mind - 1) : 101;
          3: pt = (k == 0) ? $urandom_range(3, 32767) : -$urandom_range(0, 32768);
          4: pd = (k == 0) ? 255 : 0;
          5: if (k == 0) pt = -3;
          default: ;
        endcase
      end
      push_load(k, pt, pd, k == n - 1);
    end
    gen_hi = temp;
    if ($urandom_range(9) == 0) push_load($urandom_range(7), $urandom_range(65535),
                                          $urandom_range(255), 1'b0);
  endtask

  task automatic push_random(int count, int mind);
    int done;
    done = 0;
    while (done < count) begin
      int lk;
      push_curve(mind);
      lk = $urandom_range(3, 8);
      for (int j = 0; j < lk; j++) begin
        case ($urandom_range(3))
          0: push_lookup($urandom_range(65535));
          1: push_lookup(gen_lo + $urandom_range(0, gen_hi - gen_lo));
          2: push_lookup(gen_lo - 100 + $urandom_range(0, gen_hi - gen_lo + 200));
          default: push_lookup($urandom_range(1) ? gen_lo : gen_hi);
        endcase
      end
      done += lk + MaxPoints / 2 + 1;
    end
  endtask

  // sample away from the driving edge so queue and valid are settled
  task automatic drain_block();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_min_duty(int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v[6:0];
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    min_duty = v[6:0];
  endtask

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    act_count = 0;
    min_duty  = 7'd20;
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = 0;
    results_seen = 0;
    fail_cnt  = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: no curve, then fill every staged position with a full curve
    push_lookup(0);
    push_lookup(-32768);
    push_lookup(32767);
    for (int k = 0; k < MaxPoints; k++)
      push_load(k, k * 4000 - 2 + (k == 0 ? 0 : 3), 20 + k * 11, k == MaxPoints - 1);
    push_lookup(-32768);
    push_lookup(32767);
    push_lookup(5000);
    push_lookup(2);
    // single point, first temp off zero, duty over 100, falling duty, duty under min, flat temp
    push_load(0, 0, 50, 1'b1);
    push_load(0, 3, 50, 1'b0);
    push_load(1, 100, 60, 1'b1);
    push_load(0, 0, 255, 1'b0);
    push_load(1, 100, 60, 1'b1);
    push_load(0, 0, 60, 1'b0);
    push_load(1, 100, 40, 1'b1);
    push_load(0, -2, 19, 1'b0);
    push_load(1, 100, 60, 1'b1);
    push_load(0, 1, 100, 1'b0);
    push_load(1, 1, 100, 1'b1);
    drain_block();

    push_random(300, 20);
    drain_block();

    write_min_duty(0);
    idle_pct = 46;
    push_random(150, 0);
    drain_block();

    write_min_duty(100);
    idle_pct  = 0;
    stall_pct = 46;
    push_random(100, 100);
    drain_block();

    write_min_duty(127);
    push_random(60, 100);
    drain_block();

    write_min_duty(35);
    idle_pct  = 32;
    stall_pct = 32;
    push_random(200, 35);
    drain_block();

    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: fan_curve_spline_lookup_unit.f
hdl/fcsl_pkg.sv
hdl/fcsl_ctrl.sv
hdl/fcsl_dp.sv
hdl/fan_curve_spline_lookup_unit.sv
sim/tb_fan_curve_spline_lookup_unit.sv
